[rtl/core/spa_pkg.sv]
// ----------------------------------------------------------------------------
// Subnet pool allocator package
// Shared constants, the candidate table, codes and the control/status types
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spa_pkg;

	// Table sizes.
	localparam int NUM_CANDIDATES    = 18;
	localparam int MAX_USED          = 32;
	localparam int LISTED_CANDIDATES = 18;
	localparam int CAND_N = (NUM_CANDIDATES < LISTED_CANDIDATES) ?
		NUM_CANDIDATES : LISTED_CANDIDATES;

	// Field widths.
	localparam int ADDR_W = 32;
	localparam int PFX_W  = 6;
	localparam int IDX_W  = 5;
	localparam int USED_W = ADDR_W + PFX_W;

	// In-use list addressing and fill count.
	localparam int USED_AW = (MAX_USED > 1) ? $clog2(MAX_USED) : 1;
	localparam int UCNT_W  = $clog2(MAX_USED + 1);

	localparam logic [PFX_W-1:0] CAND_PREFIX = 6'd30;
	localparam logic [PFX_W-1:0] PFX_MAX     = 6'd32;

	localparam logic [ADDR_W-1:0] CAND_TABLE [LISTED_CANDIDATES] = '{
		32'hAC103A01, 32'hAC113A01, 32'hAC123A01, 32'hAC133A01,
		32'hAC143A01, 32'hAC153A01, 32'hAC163A01, 32'hAC173A01,
		32'hAC183A01, 32'hAC193A01, 32'hAC1A3A01, 32'hAC1B3A01,
		32'hAC1C3A01, 32'hAC1D3A01, 32'hAC1E3A01, 32'hAC1F3A01,
		32'hC0A83A01, 32'h0A111401
	};

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_FIND  = 2'd2,
		ACT_FREE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOT_RES = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the accepted item, restart the scan
		logic exec;      // run clear, add or free
		logic scan_step; // walk the in-use list
		logic pick;      // choose and reserve the first free candidate
		logic out_load;  // move the result into the output register
	} spa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
	} spa_stat_t;

endpackage

[rtl/core/spa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/spa_ctrl.sv]
// ----------------------------------------------------------------------------
// Subnet pool allocator controller
// Sequences one item at a time: accept, execute or scan and pick, then
// hand the result to the output register.
// ----------------------------------------------------------------------------
module spa_ctrl
	import spa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [1:0] action,
	output logic      out_valid,
	input  logic      out_stall,
	input  spa_stat_t stat,
	output spa_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SCAN = 5'b00100,
		S_PICK = 5'b01000,
		S_PUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	// The output register can take a result when empty or being drained.
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.load      = accept;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (action_t'(action) == ACT_FIND) ? S_SCAN : S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_PUSH;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_PUSH;
			end
			S_PUSH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/spa_datapath.sv]
// ----------------------------------------------------------------------------
// Subnet pool allocator datapath
// Holds the reserved marks, the in-use list and its fill count, the overlap
// lanes for the candidates, and the result and output registers.
// ----------------------------------------------------------------------------
module spa_datapath
	import spa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  spa_cmd_t          cmd,
	output spa_stat_t         stat,
	input  logic [1:0]        action,
	input  logic [ADDR_W-1:0] net_address,
	input  logic [PFX_W-1:0]  net_prefix,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] found_address,
	output logic [PFX_W-1:0]  found_prefix,
	output logic [IDX_W-1:0]  found_index
);

	// Captured item.
	action_t           act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PFX_W-1:0]  pfx_q;

	logic [UCNT_W-1:0] used_cnt_q;
	logic [UCNT_W-1:0] scan_cnt_q;
	logic [CAND_N-1:0] reserved_q;
	logic [CAND_N-1:0] clash_q;
	logic              rd_vld_s1;

	// Result waiting for the output register.
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [PFX_W-1:0]  res_pfx_q;
	logic [IDX_W-1:0]  res_idx_q;

	logic [ADDR_W-1:0] out_addr_q;
	logic [PFX_W-1:0]  out_pfx_q;
	logic [IDX_W-1:0]  out_idx_q;
	status_t           out_status_q;

	// In-use list memory.
	logic              ram_we;
	logic [USED_W-1:0] ram_wdata;
	logic [USED_W-1:0] ram_rdata;
	logic              rd_issue;
	logic [PFX_W-1:0]  sat_pfx;

	spa_ram #(
		.WIDTH (USED_W),
		.DEPTH (MAX_USED)
	) u_used_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (used_cnt_q[USED_AW-1:0]),
		.wdata (ram_wdata),
		.raddr (scan_cnt_q[USED_AW-1:0]),
		.rdata (ram_rdata)
	);

	logic list_full;

	assign list_full = (used_cnt_q >= UCNT_W'(MAX_USED));
	assign sat_pfx   = (pfx_q > PFX_MAX) ? PFX_MAX : pfx_q;
	assign ram_wdata = {addr_q, sat_pfx};
	assign ram_we    = cmd.exec && (act_q == ACT_ADD) && !list_full;
	assign rd_issue  = cmd.scan_step && (scan_cnt_q < used_cnt_q);

	assign stat.scan_done = (scan_cnt_q >= used_cnt_q) && !rd_vld_s1;

	// Overlap of one in-use entry with every candidate: the candidates are
	// all /30, so the compare covers the top min(30, prefix) bits.
	logic [ADDR_W-1:0] ent_addr;
	logic [PFX_W-1:0]  ent_pfx;
	logic [PFX_W-1:0]  min_pfx;
	logic [ADDR_W-1:0] ovl_mask;
	logic [CAND_N-1:0] hit_vec;

	assign ent_addr = ram_rdata[USED_W-1:PFX_W];
	assign ent_pfx  = ram_rdata[PFX_W-1:0];
	assign min_pfx  = (ent_pfx < CAND_PREFIX) ? ent_pfx : CAND_PREFIX;
	assign ovl_mask = (min_pfx == '0) ? '0 :
		({ADDR_W{1'b1}} << (PFX_W'(ADDR_W) - min_pfx));

	always_comb begin
		for (int i = 0; i < CAND_N; i++) begin
			hit_vec[i] = ((CAND_TABLE[i] ^ ent_addr) & ovl_mask) == '0;
		end
	end

	// Lowest free candidate after the scan.
	logic              pick_any;
	logic [IDX_W-1:0]  pick_idx;
	logic [ADDR_W-1:0] pick_addr;

	always_comb begin
		pick_any  = 1'b0;
		pick_idx  = '0;
		pick_addr = '0;
		for (int i = CAND_N - 1; i >= 0; i--) begin
			if (!reserved_q[i] && !clash_q[i]) begin
				pick_any  = 1'b1;
				pick_idx  = IDX_W'(i);
				pick_addr = CAND_TABLE[i];
			end
		end
	end

	// Candidate that a free names; the listed addresses are distinct.
	logic [CAND_N-1:0] free_match;
	logic              free_res;
	logic [IDX_W-1:0]  free_idx;

	always_comb begin
		free_res = 1'b0;
		free_idx = '0;
		for (int i = 0; i < CAND_N; i++) begin
			free_match[i] = (CAND_TABLE[i] == addr_q) && (pfx_q == CAND_PREFIX);
		end
		for (int i = CAND_N - 1; i >= 0; i--) begin
			if (free_match[i]) begin
				free_res = reserved_q[i];
				free_idx = IDX_W'(i);
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_cnt_q <= '0;
			scan_cnt_q <= '0;
			reserved_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (cmd.load) begin
				scan_cnt_q <= '0;
			end else if (rd_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (cmd.exec) begin
				case (act_q)
					ACT_CLEAR: used_cnt_q <= '0;
					ACT_ADD: begin
						if (!list_full) begin
							used_cnt_q <= used_cnt_q + 1'b1;
						end
					end
					ACT_FREE: begin
						if (free_res) begin
							reserved_q <= reserved_q & ~free_match;
						end
					end
					default: ;
				endcase
			end
			if (cmd.pick && pick_any) begin
				for (int i = 0; i < CAND_N; i++) begin
					if (pick_idx == IDX_W'(i)) begin
						reserved_q[i] <= 1'b1;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action_t'(action);
			addr_q  <= net_address;
			pfx_q   <= net_prefix;
			clash_q <= '0;
		end else if (rd_vld_s1) begin
			clash_q <= clash_q | hit_vec;
		end

		if (cmd.exec) begin
			res_addr_q <= '0;
			res_pfx_q  <= '0;
			res_idx_q  <= '0;
			case (act_q)
				ACT_ADD:  res_status_q <= list_full ? ST_FULL : ST_OK;
				ACT_FREE: begin
					res_status_q <= free_res ? ST_OK : ST_NOT_RES;
					res_idx_q    <= free_res ? free_idx : '0;
				end
				default:  res_status_q <= ST_OK;
			endcase
		end else if (cmd.pick) begin
			res_status_q <= pick_any ? ST_OK : ST_NO_FREE;
			res_addr_q   <= pick_addr;
			res_pfx_q    <= pick_any ? CAND_PREFIX : '0;
			res_idx_q    <= pick_idx;
		end

		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
			out_pfx_q    <= res_pfx_q;
			out_idx_q    <= res_idx_q;
		end
	end

	assign status        = out_status_q;
	assign found_address = out_addr_q;
	assign found_prefix  = out_pfx_q;
	assign found_index   = out_idx_q;

endmodule

[rtl/core/subnet_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// Subnet pool allocator core
// Clears or extends a list of in-use IPv4 subnets, reserves the first free
// candidate subnet that overlaps none of them, and frees reservations.
// ----------------------------------------------------------------------------
// The block works on one item at a time. Clear, add and free pass through
// an execute state, which writes the result register, and a push state,
// which moves the result into the output register once that register is
// free. A find reads the in-use list from its RAM one entry per cycle,
// comparing each entry against all candidates at once, then picks the lowest
// free candidate and pushes the result the same way. A new item is accepted
// once the previous result has entered the output register, even if that
// result is still waiting to be taken. The in-use list needs no clearing
// after reset; the block takes items as soon as reset is released.
module subnet_pool_allocator_core
	import spa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [ADDR_W-1:0] net_address,
	input  logic [PFX_W-1:0]  net_prefix,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] found_address,
	output logic [PFX_W-1:0]  found_prefix,
	output logic [IDX_W-1:0]  found_index
);

	spa_cmd_t  cmd;
	spa_stat_t stat;

	spa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	spa_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.net_address   (net_address),
		.net_prefix    (net_prefix),
		.status        (status),
		.found_address (found_address),
		.found_prefix  (found_prefix),
		.found_index   (found_index)
	);

endmodule
